>>> rtl/srjc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper ramp jog controller package
// Shared types, register indexes and reset values of the controller.
// ----------------------------------------------------------------------------
package srjc_pkg;

	localparam int unsigned RegIdxW = 3;
	localparam int unsigned CfgDataW = 12;
	localparam int unsigned FiltW = 10;
	localparam int unsigned SpeedW = 12;
	localparam int unsigned PhaseW = 13;
	localparam int unsigned SampleW = 10;

	localparam logic [RegIdxW-1:0] REG_PUSH_TICKS = 3'd0;
	localparam logic [RegIdxW-1:0] REG_HOLD_TICKS = 3'd1;
	localparam logic [RegIdxW-1:0] REG_ACCEL_STEP = 3'd2;
	localparam logic [RegIdxW-1:0] REG_PHASE_WRAP = 3'd3;
	localparam logic [RegIdxW-1:0] REG_RAMP_INTERVAL = 3'd4;
	localparam logic [RegIdxW-1:0] REG_SAMPLE_INTERVAL = 3'd5;
	localparam logic [RegIdxW-1:0] REG_SPEED_OFFSET = 3'd6;

	localparam logic [9:0] RST_PUSH_TICKS = 10'd100;
	localparam logic [9:0] RST_HOLD_TICKS = 10'd1000;
	localparam logic [7:0] RST_ACCEL_STEP = 8'd5;
	localparam logic [11:0] RST_PHASE_WRAP = 12'd1500;
	localparam logic [3:0] RST_RAMP_INTERVAL = 4'd10;
	localparam logic [9:0] RST_SAMPLE_INTERVAL = 10'd500;
	localparam logic [11:0] RST_SPEED_OFFSET = 12'd200;

	localparam logic [SpeedW-1:0] SPEED_MAX = 12'd4095;

	typedef enum logic [1:0] {
		SEQ_IDLE = 2'd0,
		SEQ_ACCEL = 2'd1,
		SEQ_DECEL = 2'd2
	} seq_step_t;

	typedef enum logic [2:0] {
		RUN_STOP = 3'd0,
		RUN_FWD_PUSH = 3'd1,
		RUN_FWD_HOLD = 3'd2,
		RUN_BWD_PUSH = 3'd3,
		RUN_BWD_HOLD = 3'd4
	} run_mode_t;

	typedef enum logic [1:0] {
		RAMP_NONE = 2'd0,
		RAMP_UP = 2'd1,
		RAMP_DOWN = 2'd2
	} ramp_sign_t;

	typedef struct packed {
		logic [9:0] push_ticks;
		logic [9:0] hold_ticks;
		logic [7:0] accel_step;
		logic [11:0] phase_wrap;
		logic [3:0] ramp_interval;
		logic [9:0] sample_interval;
		logic [11:0] speed_offset;
	} cfg_t;

	typedef struct packed {
		logic [FiltW-1:0] filt;
		logic stat;
		logic hold;
	} btn_t;

	typedef struct packed {
		logic [PhaseW-1:0] phase;
		logic [SpeedW-1:0] speed;
		logic [3:0] ramp_cnt;
		logic [SampleW-1:0] sample_cnt;
		logic [SpeedW-1:0] limit;
		logic step_pin;
	} motion_t;

	typedef struct packed {
		seq_step_t step;
		run_mode_t run;
		ramp_sign_t sign;
		logic [SpeedW-1:0] speed;
		logic dir;
		logic en;
	} seq_t;

endpackage

`default_nettype wire

>>> rtl/srjc_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Button filter
// Counts a button up while active and down while idle, raising the pressed
// and hold flags and reporting a push when a long enough press ends.
// ----------------------------------------------------------------------------
module srjc_filter (
	input  wire logic                 act,
	input  wire logic [9:0]           push_ticks,
	input  wire logic [9:0]           hold_ticks,
	input  wire srjc_pkg::btn_t       cur,
	output srjc_pkg::btn_t            nxt,
	output logic                      push
);
	import srjc_pkg::*;

	logic [FiltW-1:0] inc;

	assign inc = cur.filt + 10'd1;

	always_comb begin
		nxt = cur;
		push = 1'b0;
		if (act) begin
			if (cur.filt < hold_ticks) begin
				nxt.filt = inc;
				if (inc >= push_ticks) begin
					nxt.stat = 1'b1;
				end
			end else begin
				nxt.hold = 1'b1;
			end
		end else if (cur.filt > push_ticks) begin
			nxt.filt = push_ticks;
			push = cur.stat;
		end else if (cur.filt != '0) begin
			nxt.filt = cur.filt - 10'd1;
		end else begin
			nxt.stat = 1'b0;
			nxt.hold = 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> rtl/srjc_motion.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Motion datapath
// Phase accumulator with step pin toggle, periodic speed ramp with clamping
// and periodic re-latch of the speed limit from the sample.
// ----------------------------------------------------------------------------
module srjc_motion (
	input  wire srjc_pkg::cfg_t       cfg,
	input  wire srjc_pkg::ramp_sign_t sign,
	input  wire logic [9:0]           sample,
	input  wire srjc_pkg::motion_t    cur,
	output srjc_pkg::motion_t         nxt
);
	import srjc_pkg::*;

	logic [PhaseW:0] phase_sum;
	logic [PhaseW:0] phase_sub;
	logic signed [SpeedW+1:0] ramp_s;
	logic signed [SpeedW+1:0] limit_s;
	logic [SpeedW:0] lim_sum;
	logic [3:0] ramp_base;
	logic [SampleW-1:0] sample_base;

	assign phase_sum = {1'b0, cur.phase} + {2'b00, cur.speed};
	assign phase_sub = phase_sum - {2'b00, cfg.phase_wrap};
	assign limit_s = $signed({2'b00, cur.limit});
	assign lim_sum = {3'b000, sample} + {1'b0, cfg.speed_offset};

	always_comb begin
		nxt = cur;

		if (cur.speed != '0) begin
			if (phase_sum > {2'b00, cfg.phase_wrap}) begin
				nxt.phase = phase_sub[PhaseW-1:0];
				nxt.step_pin = ~cur.step_pin;
			end else begin
				nxt.phase = phase_sum[PhaseW-1:0];
			end
		end else begin
			nxt.phase = '0;
		end

		ramp_s = $signed({2'b00, cur.speed});
		ramp_base = cur.ramp_cnt;
		if (cur.ramp_cnt == cfg.ramp_interval) begin
			case (sign)
				RAMP_UP: ramp_s = ramp_s + $signed({6'b000000, cfg.accel_step});
				RAMP_DOWN: ramp_s = ramp_s - $signed({6'b000000, cfg.accel_step});
				default: ramp_s = ramp_s;
			endcase
			if (ramp_s >= limit_s) begin
				ramp_s = limit_s;
			end
			if (ramp_s < 0) begin
				ramp_s = '0;
			end
			nxt.speed = ramp_s[SpeedW-1:0];
			ramp_base = '0;
		end
		nxt.ramp_cnt = ramp_base + 4'd1;

		sample_base = cur.sample_cnt;
		if (cur.sample_cnt >= cfg.sample_interval) begin
			nxt.limit = lim_sum[SpeedW] ? SPEED_MAX : lim_sum[SpeedW-1:0];
			sample_base = '0;
		end
		nxt.sample_cnt = sample_base + 10'd1;
	end

endmodule

`default_nettype wire

>>> rtl/srjc_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Run sequencer
// Idle, accelerating and decelerating steps. One pass with this tick's
// pushes, then further passes without pushes until the step settles.
// ----------------------------------------------------------------------------
module srjc_seq (
	input  wire logic             fpush,
	input  wire logic             bpush,
	input  wire logic             fhold,
	input  wire logic             bhold,
	input  wire logic             rhold,
	input  wire srjc_pkg::seq_t   cur,
	output srjc_pkg::seq_t        nxt
);
	import srjc_pkg::*;

	function automatic seq_t seq_once(seq_t st, logic fp, logic bp, logic fh, logic bh,
			logic rh);
		seq_t r;
		r = st;
		case (st.step)
			SEQ_IDLE: begin
				r.run = RUN_STOP;
				if (fp) r.run = RUN_FWD_PUSH;
				if (bp) r.run = RUN_BWD_PUSH;
				if (fh) r.run = RUN_FWD_HOLD;
				if (bh) r.run = RUN_BWD_HOLD;
				if (r.run != RUN_STOP) begin
					r.dir = (r.run inside {RUN_FWD_PUSH, RUN_FWD_HOLD});
					r.en = 1'b1;
					r.speed = '0;
					r.sign = RAMP_UP;
					r.step = SEQ_ACCEL;
				end else begin
					r.en = ~rh;
				end
			end
			SEQ_ACCEL: begin
				if (((st.run == RUN_FWD_PUSH || st.run == RUN_BWD_PUSH) && (fp || bp))
						|| (st.run == RUN_FWD_HOLD && !fh)
						|| (st.run == RUN_BWD_HOLD && !bh)) begin
					r.sign = RAMP_DOWN;
					r.step = SEQ_DECEL;
				end
			end
			SEQ_DECEL: begin
				if (st.speed == '0) begin
					r.sign = RAMP_NONE;
					r.step = SEQ_IDLE;
				end
			end
			default: begin
				r.step = SEQ_IDLE;
			end
		endcase
		return r;
	endfunction

	seq_t first;
	seq_t pass;
	logic active;

	assign first = seq_once(cur, fpush, bpush, fhold, bhold, rhold);

	always_comb begin
		nxt = first;
		active = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (active) begin
				pass = seq_once(nxt, 1'b0, 1'b0, fhold, bhold, rhold);
				if (pass.step == nxt.step) begin
					active = 1'b0;
				end
				nxt = pass;
			end else begin
				pass = nxt;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/stepper_ramp_jog_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper ramp jog controller
// Each request is one step tick carrying the forward, backward and release
// inputs and a speed sample. The block filters the buttons into push and
// hold events, drives the step, direction and enable pins and ramps the
// speed between zero and a limit taken from the sample plus an offset.
//
// The input channel takes one request per cycle. All work for a tick is done
// in the cycle of acceptance, and the controller state registers double as
// the result register, so the result appears in the cycle after acceptance.
// A new request is taken whenever the result slot is empty or is being
// taken in the same cycle, giving one tick per clock with the receiver
// ready. When the receiver stalls, the result holds and the input stalls
// with it. Configuration writes through the write port take effect at once.
// Reset loads the default register values, clears the filters, flags,
// counters, speed and phase, drives all pins low and sets the limit to the
// default offset.
// ----------------------------------------------------------------------------
module stepper_ramp_jog_controller (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            write_enable,
	input  wire logic [srjc_pkg::RegIdxW-1:0]    write_index,
	input  wire logic [srjc_pkg::CfgDataW-1:0]   write_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            forward_pressed,
	input  wire logic                            backward_pressed,
	input  wire logic                            release_active,
	input  wire logic [9:0]                      speed_sample,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 step_level,
	output logic                                 direction_forward,
	output logic                                 driver_enable,
	output logic [11:0]                          current_speed
);
	import srjc_pkg::*;

	cfg_t cfg_q;
	motion_t mot_q;
	motion_t mot_nxt;
	btn_t fwd_q;
	btn_t fwd_nxt;
	btn_t bwd_q;
	btn_t bwd_nxt;
	logic [FiltW-1:0] rel_filt_q;
	logic [FiltW-1:0] rel_filt_nxt;
	logic rhold_q;
	logic rhold_nxt;
	logic fpush;
	logic bpush;
	seq_step_t step_q;
	run_mode_t run_q;
	ramp_sign_t sign_q;
	logic dir_q;
	logic en_q;
	logic out_valid_q;
	logic acc;
	seq_t seq_cur;
	seq_t seq_nxt;

	assign in_ready = ~out_valid_q | out_ready;
	assign acc = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.push_ticks <= RST_PUSH_TICKS;
			cfg_q.hold_ticks <= RST_HOLD_TICKS;
			cfg_q.accel_step <= RST_ACCEL_STEP;
			cfg_q.phase_wrap <= RST_PHASE_WRAP;
			cfg_q.ramp_interval <= RST_RAMP_INTERVAL;
			cfg_q.sample_interval <= RST_SAMPLE_INTERVAL;
			cfg_q.speed_offset <= RST_SPEED_OFFSET;
		end else if (write_enable) begin
			case (write_index)
				REG_PUSH_TICKS: cfg_q.push_ticks <= write_data[9:0];
				REG_HOLD_TICKS: cfg_q.hold_ticks <= write_data[9:0];
				REG_ACCEL_STEP: cfg_q.accel_step <= write_data[7:0];
				REG_PHASE_WRAP: cfg_q.phase_wrap <= write_data[11:0];
				REG_RAMP_INTERVAL: cfg_q.ramp_interval <= write_data[3:0];
				REG_SAMPLE_INTERVAL: cfg_q.sample_interval <= write_data[9:0];
				REG_SPEED_OFFSET: cfg_q.speed_offset <= write_data[11:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	srjc_motion u_motion (
		.cfg    (cfg_q),
		.sign   (sign_q),
		.sample (speed_sample),
		.cur    (mot_q),
		.nxt    (mot_nxt)
	);

	srjc_filter u_fwd_filter (
		.act        (forward_pressed),
		.push_ticks (cfg_q.push_ticks),
		.hold_ticks (cfg_q.hold_ticks),
		.cur        (fwd_q),
		.nxt        (fwd_nxt),
		.push       (fpush)
	);

	srjc_filter u_bwd_filter (
		.act        (backward_pressed),
		.push_ticks (cfg_q.push_ticks),
		.hold_ticks (cfg_q.hold_ticks),
		.cur        (bwd_q),
		.nxt        (bwd_nxt),
		.push       (bpush)
	);

	always_comb begin
		rel_filt_nxt = rel_filt_q;
		rhold_nxt = rhold_q;
		if (release_active) begin
			if (rel_filt_q < cfg_q.push_ticks) begin
				rel_filt_nxt = rel_filt_q + 10'd1;
			end else begin
				rhold_nxt = 1'b1;
			end
		end else if (rel_filt_q != '0) begin
			rel_filt_nxt = rel_filt_q - 10'd1;
		end else begin
			rhold_nxt = 1'b0;
		end
	end

	always_comb begin
		seq_cur.step = step_q;
		seq_cur.run = run_q;
		seq_cur.sign = sign_q;
		seq_cur.speed = mot_nxt.speed;
		seq_cur.dir = dir_q;
		seq_cur.en = en_q;
	end

	srjc_seq u_seq (
		.fpush (fpush),
		.bpush (bpush),
		.fhold (fwd_nxt.hold),
		.bhold (bwd_nxt.hold),
		.rhold (rhold_nxt),
		.cur   (seq_cur),
		.nxt   (seq_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mot_q.phase <= '0;
			mot_q.speed <= '0;
			mot_q.ramp_cnt <= '0;
			mot_q.sample_cnt <= '0;
			mot_q.limit <= RST_SPEED_OFFSET;
			mot_q.step_pin <= 1'b0;
			fwd_q <= '0;
			bwd_q <= '0;
			rel_filt_q <= '0;
			rhold_q <= 1'b0;
			step_q <= SEQ_IDLE;
			run_q <= RUN_STOP;
			sign_q <= RAMP_NONE;
			dir_q <= 1'b0;
			en_q <= 1'b0;
		end else if (acc) begin
			mot_q.phase <= mot_nxt.phase;
			mot_q.speed <= seq_nxt.speed;
			mot_q.ramp_cnt <= mot_nxt.ramp_cnt;
			mot_q.sample_cnt <= mot_nxt.sample_cnt;
			mot_q.limit <= mot_nxt.limit;
			mot_q.step_pin <= mot_nxt.step_pin;
			fwd_q <= fwd_nxt;
			bwd_q <= bwd_nxt;
			rel_filt_q <= rel_filt_nxt;
			rhold_q <= rhold_nxt;
			step_q <= seq_nxt.step;
			run_q <= seq_nxt.run;
			sign_q <= seq_nxt.sign;
			dir_q <= seq_nxt.dir;
			en_q <= seq_nxt.en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign step_level = mot_q.step_pin;
	assign direction_forward = dir_q;
	assign driver_enable = en_q;
	assign current_speed = mot_q.speed;

	a_run_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == SEQ_ACCEL || step_q == SEQ_DECEL) |-> en_q)
		else $error("driver disabled while a run is in progress");

	a_idle_no_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == SEQ_IDLE) |-> (sign_q == RAMP_NONE))
		else $error("ramp active while the sequencer is idle");

	a_phase_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && mot_q.speed == '0) |=> (mot_q.phase == '0))
		else $error("phase not cleared at zero speed");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> ($stable(mot_q) && $stable(step_q)))
		else $error("controller state changed while the result was stalled");

endmodule

`default_nettype wire
